// ----- rtl/pvrot_pkg.sv -----
// ----------------------------------------------------------------------------
// pvrot_pkg
// shared constants, arctangent table and stream widths for the rotate core
// ----------------------------------------------------------------------------
package pvrot_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int MATRIX_FRAC_BITS  = 30;
    localparam int TRIG_FRAC         = 30;

    localparam logic [31:0] MAT_ONE  = 32'(64'd1 << MATRIX_FRAC_BITS);

    // commands carried in tuser
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_PROJECT = 2'd2;
    localparam logic [1:0] CMD_ROTATE  = 2'd3;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 176;

    // arctangent table in phase units (2^32 per turn)
    function automatic logic [31:0] pvrot_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/pvrot_mul.sv -----
// ----------------------------------------------------------------------------
// pvrot_mul
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module pvrot_mul import pvrot_pkg::*; (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/pvrot_cordic.sv -----
// ----------------------------------------------------------------------------
// pvrot_cordic
// iterative cordic, one rotation step per cycle, gives cos and sin of an angle
// ----------------------------------------------------------------------------
module pvrot_cordic import pvrot_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [4:0]         r_it, n_it;
    logic               r_flip, n_flip;
    logic signed [33:0] r_x, n_x, r_y, n_y, r_z, n_z;

    logic [16:0]        mag;
    logic [17:0]        tq;
    logic [1:0]         q;
    logic signed [33:0] pm, ps, pw, pr;
    logic               flip;
    logic signed [33:0] xs, ys, at;

    // phase = round(angle * 2^31 / 32767); 2^31 = 32767*65538 + 2
    always_comb begin
        mag = i_angle[15] ? (17'd0 - {1'b1, i_angle}) : {1'b0, i_angle};
        tq  = {mag, 1'b0} + 18'd16383;
        q   = 2'(tq >= 18'd32767) + 2'(tq >= 18'd65534);
        pm  = (34'(mag) << 16) + (34'(mag) << 1) + 34'(q);
        ps  = i_angle[15] ? -pm : pm;
        pw  = (ps < -34'sd2147483648) ? ps + 34'sd4294967296 : ps;
        flip = 1'b0;
        pr   = pw;
        if (pw > 34'sd1073741824) begin
            pr   = pw - 34'sd2147483648;
            flip = 1'b1;
        end else if (pw < -34'sd1073741824) begin
            pr   = pw + 34'sd2147483648;
            flip = 1'b1;
        end
    end

    assign xs = r_x >>> r_it;
    assign ys = r_y >>> r_it;
    assign at = 34'(pvrot_atan(r_it));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_it   = r_it;
        n_flip = r_flip;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_busy = 1'b1;
            n_it   = 5'd0;
            n_flip = flip;
            n_x    = 34'sh026DD3B6A;
            n_y    = 34'sd0;
            n_z    = pr;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end
            n_it = r_it + 5'd1;
            if (r_it == 5'(CORDIC_ITERATIONS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_it   <= n_it;
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? 32'(-r_x) : 32'(r_x);
    assign o_sin  = r_flip ? 32'(-r_y) : 32'(r_y);

endmodule

// ----- rtl/packed_vector_project_euler_rotate_core.sv -----
// ----------------------------------------------------------------------------
// packed_vector_project_euler_rotate_core
// 3x3 q2.30 matrix: entry write/read, packed vector projection, euler rotation
// ----------------------------------------------------------------------------
// sequence: entry write/read go from accept to the output state, project only
//   runs 9 products, each issued then accumulated, project and rotate adds 3
//   cordic runs, then per column 3 loads, 6 product pairs, 3 stores
// throughput: one transaction at a time, next accept after the output state
// reset: synchronous active low, matrix returns to identity, no result pending
// ----------------------------------------------------------------------------
module packed_vector_project_euler_rotate_core import pvrot_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, entry_value, packed_x, packed_y, packed_z,
    // angle_x, angle_y, angle_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tail_x, tail_y, tail_z, read_value
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PROJ   = 3'd1;
    localparam logic [2:0] ST_TRIG   = 3'd2;
    localparam logic [2:0] ST_RLOAD  = 3'd3;
    localparam logic [2:0] ST_RMIX   = 3'd4;
    localparam logic [2:0] ST_RSTORE = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // input fields
    logic [3:0]         in_idx;
    logic [31:0]        in_val;
    logic [15:0]        in_pk  [3];
    logic [15:0]        in_ang [3];

    assign in_idx    = s_axis_tdata[3:0];
    assign in_val    = s_axis_tdata[35:4];
    assign in_pk[0]  = s_axis_tdata[51:36];
    assign in_pk[1]  = s_axis_tdata[67:52];
    assign in_pk[2]  = s_axis_tdata[83:68];
    assign in_ang[0] = s_axis_tdata[99:84];
    assign in_ang[1] = s_axis_tdata[115:100];
    assign in_ang[2] = s_axis_tdata[131:116];

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_cmd, n_cmd;
    logic [15:0]        r_pk  [3];
    logic [15:0]        r_ang [3];
    logic [31:0]        r_mat [9];
    logic [31:0]        r_read, n_read;
    logic [47:0]        r_tail [3];
    logic signed [76:0] r_acc, n_acc;
    logic [1:0]         r_k, n_k, r_i, n_i, r_ph, n_ph;
    logic [2:0]         r_ms, n_ms;
    logic signed [31:0] r_cs [3];
    logic signed [31:0] r_sn [3];
    logic signed [31:0] r_w  [3];
    logic signed [31:0] r_tmp, n_tmp;
    logic signed [65:0] r_racc, n_racc;
    logic               r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic               accept;
    logic [3:0]         rd_addr;
    logic [31:0]        rd_data;
    logic               wr_en;
    logic [3:0]         wr_addr;
    logic [31:0]        wr_data;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               tr_start, tr_done;
    logic signed [31:0] tr_cos, tr_sin;

    // projection term and rotation sum
    logic [15:0]        pk_cur;
    logic signed [44:0] term;
    logic signed [76:0] shifted;
    logic signed [76:0] acc_sum;
    logic signed [65:0] rsum;
    logic signed [35:0] rsh;
    logic signed [31:0] rres;
    logic signed [31:0] op_p, op_a, op_q, op_b;
    logic               out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;

    pvrot_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pvrot_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tr_start),
        .i_angle (r_ang[r_k]),
        .o_done  (tr_done),
        .o_cos   (tr_cos),
        .o_sin   (tr_sin)
    );

    // single matrix read port: entry read on accept, else row i column k
    always_comb begin
        if (r_state == ST_IDLE) begin
            rd_addr = in_idx;
        end else begin
            rd_addr = 4'({r_i, 1'b0}) + 4'(r_i) + 4'(r_k);
        end
        rd_data = (rd_addr < 4'd9) ? r_mat[rd_addr] : 32'd0;
    end

    // rotation pair table: z on rows 0/1, y on rows 0/2, x on rows 1/2
    always_comb begin
        case (r_ms)
            3'd0: begin
                op_p = r_cs[2]; op_a = r_w[0]; op_q = -r_sn[2]; op_b = r_w[1];
            end
            3'd1: begin
                op_p = r_sn[2]; op_a = r_w[0]; op_q = r_cs[2];  op_b = r_w[1];
            end
            3'd2: begin
                op_p = r_cs[1]; op_a = r_w[0]; op_q = r_sn[1];  op_b = r_w[2];
            end
            3'd3: begin
                op_p = -r_sn[1]; op_a = r_w[0]; op_q = r_cs[1]; op_b = r_w[2];
            end
            3'd4: begin
                op_p = r_cs[0]; op_a = r_w[1]; op_q = -r_sn[0]; op_b = r_w[2];
            end
            default: begin
                op_p = r_sn[0]; op_a = r_w[1]; op_q = r_cs[0];  op_b = r_w[2];
            end
        endcase
    end

    // datapath pieces
    always_comb begin
        pk_cur  = r_pk[r_i];
        term    = pk_cur[15] ? -mul_p[44:0] : mul_p[44:0];
        shifted = 77'(term) <<< pk_cur[14:10];
        acc_sum = ((r_i == 2'd0) ? 77'sd0 : r_acc) + shifted;
        rsum    = r_racc + 66'(mul_p) + (66'sd1 <<< (TRIG_FRAC - 1));
        rsh     = rsum[65:30];
        if (rsh > 36'sd2147483647) begin
            rres = 32'sh7FFFFFFF;
        end else if (rsh < -36'sd2147483648) begin
            rres = 32'sh80000000;
        end else begin
            rres = rsh[31:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_read   = r_read;
        n_acc    = r_acc;
        n_k      = r_k;
        n_i      = r_i;
        n_ph     = r_ph;
        n_ms     = r_ms;
        n_tmp    = r_tmp;
        n_racc   = r_racc;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        wr_en    = 1'b0;
        wr_addr  = in_idx;
        wr_data  = in_val;
        mul_a    = 32'sd0;
        mul_b    = 32'sd0;
        tr_start = 1'b0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = s_axis_tuser;
                    n_read = 32'd0;
                    n_k    = 2'd0;
                    n_i    = 2'd0;
                    n_ph   = 2'd0;
                    if (s_axis_tuser == CMD_WRITE) begin
                        wr_en   = (in_idx < 4'd9);
                        n_state = ST_OUT;
                    end else if (s_axis_tuser == CMD_READ) begin
                        n_read  = rd_data;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_PROJ;
                    end
                end
            end
            ST_PROJ: begin
                // mantissa with hidden one times column entry
                mul_a = 32'({1'b1, pk_cur[9:0]});
                mul_b = rd_data;
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_ph  = 2'd0;
                    n_acc = acc_sum;
                    if (r_i == 2'd2) begin
                        n_i = 2'd0;
                        if (r_k == 2'd2) begin
                            n_k     = 2'd0;
                            n_state = (r_cmd == CMD_ROTATE) ? ST_TRIG : ST_OUT;
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end else begin
                        n_i = r_i + 2'd1;
                    end
                end
            end
            ST_TRIG: begin
                // r_k walks angles x, y, z
                if (r_ph == 2'd0) begin
                    tr_start = 1'b1;
                    n_ph     = 2'd1;
                end else if (tr_done) begin
                    n_ph = 2'd0;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_i     = 2'd0;
                        n_state = ST_RLOAD;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            ST_RLOAD: begin
                if (r_i == 2'd2) begin
                    n_i     = 2'd0;
                    n_ms    = 3'd0;
                    n_ph    = 2'd0;
                    n_state = ST_RMIX;
                end else begin
                    n_i = r_i + 2'd1;
                end
            end
            ST_RMIX: begin
                case (r_ph)
                    2'd0: begin
                        mul_a = op_p;
                        mul_b = op_a;
                        n_ph  = 2'd1;
                    end
                    2'd1: begin
                        mul_a  = op_q;
                        mul_b  = op_b;
                        n_racc = 66'(mul_p);
                        n_ph   = 2'd2;
                    end
                    default: begin
                        n_ph = 2'd0;
                        if (!r_ms[0]) begin
                            n_tmp = rres;
                        end
                        if (r_ms == 3'd5) begin
                            n_i     = 2'd0;
                            n_state = ST_RSTORE;
                        end else begin
                            n_ms = r_ms + 3'd1;
                        end
                    end
                endcase
            end
            ST_RSTORE: begin
                wr_en   = 1'b1;
                wr_addr = rd_addr;
                wr_data = r_w[r_i];
                if (r_i == 2'd2) begin
                    n_i = 2'd0;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = ST_OUT;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = ST_RLOAD;
                    end
                end else begin
                    n_i = r_i + 2'd1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_read, r_tail[2], r_tail[1], r_tail[0]};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            for (int e = 0; e < 9; e++) begin
                r_mat[e] <= (e % 4 == 0) ? MAT_ONE : 32'd0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (wr_en) begin
                r_mat[wr_addr] <= wr_data;
            end
        end
        r_cmd   <= n_cmd;
        r_read  <= n_read;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_i     <= n_i;
        r_ph    <= n_ph;
        r_ms    <= n_ms;
        r_tmp   <= n_tmp;
        r_racc  <= n_racc;
        r_odata <= n_odata;

        if (accept) begin
            r_pk  <= in_pk;
            r_ang <= in_ang;
            r_tail[0] <= 48'd0;
            r_tail[1] <= 48'd0;
            r_tail[2] <= 48'd0;
        end
        // column sum is final after the third term, floor by frac bits
        if (r_state == ST_PROJ && r_ph == 2'd1 && r_i == 2'd2) begin
            r_tail[r_k] <= {acc_sum[76], acc_sum[76:MATRIX_FRAC_BITS]};
        end
        if (r_state == ST_TRIG && r_ph == 2'd1 && tr_done) begin
            r_cs[r_k] <= tr_cos;
            r_sn[r_k] <= tr_sin;
        end
        if (r_state == ST_RLOAD) begin
            r_w[r_i] <= rd_data;
        end
        // odd pair member lands both rows of the stage
        if (r_state == ST_RMIX && r_ph == 2'd2 && r_ms[0]) begin
            case (r_ms)
                3'd1: begin
                    r_w[0] <= r_tmp;
                    r_w[1] <= rres;
                end
                3'd3: begin
                    r_w[0] <= r_tmp;
                    r_w[2] <= rres;
                end
                default: begin
                    r_w[1] <= r_tmp;
                    r_w[2] <= rres;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
